// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clock and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every edge
`define CHK_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CHK_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/gra_pkg.sv -----
// ----------------------------------------------------------------------------
// gra_pkg
// types and codes shared by the guillotine rectangle allocator
// ----------------------------------------------------------------------------
package gra_pkg;

   localparam int POS_W  = 12;
   localparam int SIZE_W = 13;
   localparam int STAT_W = 3;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] ST_ALLOC   = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOFIT   = 3'd1;
   localparam logic [STAT_W-1:0] ST_FREED   = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STAT_W-1:0] ST_IGNORED = 3'd4;

   typedef struct packed {
      logic              cmd;
      logic [POS_W-1:0]  rect_x;
      logic [POS_W-1:0]  rect_y;
      logic [SIZE_W-1:0] rect_w;
      logic [SIZE_W-1:0] rect_h;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  out_x;
      logic [POS_W-1:0]  out_y;
      logic [SIZE_W-1:0] out_w;
      logic [SIZE_W-1:0] out_h;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
   } rect_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_FREE_AT_N,
      WR_RS_AT_N,
      WR_RS_AT_I,
      WR_BS_AT_I,
      WR_LAST_AT_I
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef struct packed {
      logic              load_req;
      logic              scan_start;
      logic              scan_run;
      logic              latch_fit;
      logic              rd_last;
      wr_sel_type        wr_sel;
      cnt_op_type        cnt_op;
      logic              res_load;
      logic [STAT_W-1:0] res_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic zero_size;
      logic list_full;
      logic fit;
      logic scan_done;
      logic split_right;
      logic split_bottom;
   } dp_stat_type;

endpackage

// ----- rtl/gra_ram.sv -----
// ----------------------------------------------------------------------------
// gra_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module gra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/gra_ctrl.sv -----
// ----------------------------------------------------------------------------
// gra_ctrl
// sequencer for allocate and free items, owns the result valid flag
// ----------------------------------------------------------------------------
module gra_ctrl import gra_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_is_free,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ctrl_cmd_type cmd,
   input  dp_stat_type  stat
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FREE  = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_SPLIT = 7'b0001000,
      S_TAIL  = 7'b0010000,
      S_MOVE  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [STAT_W-1:0] code_ff, code_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      cmd            = '0;
      cmd.wr_sel     = WR_NONE;
      cmd.cnt_op     = CNT_HOLD;
      cmd.res_status = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req   = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = req_is_free ? S_FREE : S_SCAN;
            end
         end
         S_FREE: begin
            if (stat.zero_size) begin
               code_in = ST_IGNORED;
            end else if (stat.list_full) begin
               code_in = ST_FULL;
            end else begin
               cmd.wr_sel = WR_FREE_AT_N;
               cmd.cnt_op = CNT_INC;
               code_in    = ST_FREED;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.fit) begin
               cmd.latch_fit = 1'b1;
               state_in      = S_SPLIT;
            end else if (stat.scan_done) begin
               code_in  = ST_NOFIT;
               state_in = S_DONE;
            end
         end
         S_SPLIT: begin
            code_in = ST_ALLOC;
            if (stat.split_right && stat.split_bottom) begin
               if (stat.list_full) begin
                  code_in  = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  cmd.wr_sel = WR_RS_AT_N;
                  cmd.cnt_op = CNT_INC;
                  state_in   = S_TAIL;
               end
            end else if (stat.split_right) begin
               cmd.wr_sel = WR_RS_AT_I;
               state_in   = S_DONE;
            end else if (stat.split_bottom) begin
               cmd.wr_sel = WR_BS_AT_I;
               state_in   = S_DONE;
            end else begin
               // exact fit: fetch the last entry to fill the hole
               cmd.rd_last = 1'b1;
               state_in    = S_MOVE;
            end
         end
         S_TAIL: begin
            cmd.wr_sel = WR_BS_AT_I;
            state_in   = S_DONE;
         end
         S_MOVE: begin
            cmd.wr_sel = WR_LAST_AT_I;
            cmd.cnt_op = CNT_DEC;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.res_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         code_ff      <= ST_ALLOC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/gra_dp.sv -----
// ----------------------------------------------------------------------------
// gra_dp
// free list memory, scan pipeline, split arithmetic and result register
// ----------------------------------------------------------------------------
module gra_dp import gra_pkg::*; #(
   parameter int ATLAS_W  = 2048,
   parameter int ATLAS_H  = 2048,
   parameter int MAX_FREE = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   input  req_type      req_in,
   output rsp_type      rsp_out
);

   localparam int IDX_W  = $clog2(MAX_FREE);
   localparam int CNT_W  = $clog2(MAX_FREE + 1);
   localparam int RECT_W = $bits(rect_type);

   req_type          req_ff;
   rect_type         fit_ff;
   logic [IDX_W-1:0] fit_idx_ff;
   rsp_type          res_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             e0_init_ff, e0_init_in;
   logic             rd_zero_ff, rd_zero_in;

   logic              scan_more;
   logic [CNT_W-1:0]  count_m1;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [RECT_W-1:0] ram_q;
   rect_type          rd_rect;
   rect_type          atlas_rect;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   rect_type          wr_rect;
   rect_type          rs_rect;
   rect_type          bs_rect;
   rect_type          free_rect;

   assign atlas_rect = '{x: '0, y: '0, w: SIZE_W'(ATLAS_W), h: SIZE_W'(ATLAS_H)};
   assign free_rect  = '{x: req_ff.rect_x, y: req_ff.rect_y,
                         w: req_ff.rect_w, h: req_ff.rect_h};

   // entry zero reads as the whole atlas until it is first written
   assign rd_rect = rd_zero_ff ? atlas_rect : rect_type'(ram_q);

   assign scan_more = (scan_idx_ff < count_ff);
   assign count_m1  = count_ff - CNT_W'(1);

   assign rd_en   = (cmd.scan_run && scan_more) || cmd.rd_last;
   assign rd_addr = cmd.rd_last ? count_m1[IDX_W-1:0] : scan_idx_ff[IDX_W-1:0];

   // strips cut from the chosen entry, edges wrap to 12 bits
   assign rs_rect = '{x: fit_ff.x + req_ff.rect_w[POS_W-1:0], y: fit_ff.y,
                      w: fit_ff.w - req_ff.rect_w, h: fit_ff.h};
   assign bs_rect = '{x: fit_ff.x, y: fit_ff.y + req_ff.rect_h[POS_W-1:0],
                      w: req_ff.rect_w, h: fit_ff.h - req_ff.rect_h};

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = fit_idx_ff;
      wr_rect = rd_rect;
      case (cmd.wr_sel)
         WR_FREE_AT_N: begin
            wr_addr = count_ff[IDX_W-1:0];
            wr_rect = free_rect;
         end
         WR_RS_AT_N: begin
            wr_addr = count_ff[IDX_W-1:0];
            wr_rect = rs_rect;
         end
         WR_RS_AT_I:   wr_rect = rs_rect;
         WR_BS_AT_I:   wr_rect = bs_rect;
         WR_LAST_AT_I: wr_rect = rd_rect;
         default:      wr_en   = 1'b0;
      endcase
   end

   gra_ram #(
      .WIDTH (RECT_W),
      .DEPTH (MAX_FREE)
   ) u_list (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rect),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      scan_idx_in = scan_idx_ff;
      chk_vld_in  = chk_vld_ff;
      chk_idx_in  = chk_idx_ff;
      if (cmd.scan_start) begin
         scan_idx_in = '0;
         chk_vld_in  = 1'b0;
      end else if (cmd.scan_run) begin
         if (scan_more) begin
            scan_idx_in = scan_idx_ff + CNT_W'(1);
            chk_vld_in  = 1'b1;
            chk_idx_in  = scan_idx_ff[IDX_W-1:0];
         end else begin
            chk_vld_in = 1'b0;
         end
      end
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CNT_W'(1);
         CNT_DEC: count_in = count_m1;
         default: count_in = count_ff;
      endcase
   end

   assign e0_init_in = e0_init_ff && !(wr_en && (wr_addr == '0));
   assign rd_zero_in = rd_en ? ((rd_addr == '0) && e0_init_ff) : rd_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= CNT_W'(1);
         scan_idx_ff <= '0;
         chk_vld_ff  <= 1'b0;
         chk_idx_ff  <= '0;
         e0_init_ff  <= 1'b1;
         rd_zero_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         scan_idx_ff <= scan_idx_in;
         chk_vld_ff  <= chk_vld_in;
         chk_idx_ff  <= chk_idx_in;
         e0_init_ff  <= e0_init_in;
         rd_zero_ff  <= rd_zero_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_in;
      end
      if (cmd.latch_fit) begin
         fit_ff     <= rd_rect;
         fit_idx_ff <= chk_idx_ff;
      end
      if (cmd.res_load) begin
         if (cmd.res_status == ST_ALLOC) begin
            res_ff <= '{status: ST_ALLOC, out_x: fit_ff.x, out_y: fit_ff.y,
                        out_w: req_ff.rect_w, out_h: req_ff.rect_h};
         end else begin
            res_ff <= '{status: cmd.res_status, out_x: '0, out_y: '0,
                        out_w: '0, out_h: '0};
         end
      end
   end

   assign stat.zero_size    = (req_ff.rect_w == '0) || (req_ff.rect_h == '0);
   assign stat.list_full    = (count_ff == CNT_W'(MAX_FREE));
   assign stat.fit          = chk_vld_ff && (req_ff.rect_w <= rd_rect.w)
                              && (req_ff.rect_h <= rd_rect.h);
   assign stat.scan_done    = !chk_vld_ff && !scan_more;
   assign stat.split_right  = (fit_ff.w > req_ff.rect_w);
   assign stat.split_bottom = (fit_ff.h > req_ff.rect_h);

   assign rsp_out = res_ff;

endmodule

// ----- rtl/guillotine_rect_allocator.sv -----
// free: the item is appended unless it has zero size or the list is full, then its result is registered
// allocate: entries are scanned in order up to the first fit; cutting both strips adds the
//   tail state, an exact fit the move state; no fit scans all n entries
// one item at a time; the next item is taken only after the result is registered
// reset is synchronous; the list holds the whole atlas at once, no clearing pass
// ----------------------------------------------------------------------------
// guillotine_rect_allocator
// first-fit guillotine allocator over an ordered free rectangle list
// ----------------------------------------------------------------------------
module guillotine_rect_allocator import gra_pkg::*; #(
   parameter int ATLAS_W  = 2048,
   parameter int ATLAS_H  = 2048,
   parameter int MAX_FREE = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   gra_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_free (req.cmd == CMD_FREE),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .stat        (stat)
   );

   gra_dp #(
      .ATLAS_W  (ATLAS_W),
      .ATLAS_H  (ATLAS_H),
      .MAX_FREE (MAX_FREE)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .stat    (stat),
      .req_in  (req),
      .rsp_out (rsp)
   );

endmodule

// ----- rtl/gra_check.sv -----
// ----------------------------------------------------------------------------
// gra_check
// port level checks for the rectangle allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gra_check import gra_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   logic fields_clear;

   // only an allocated item carries a rectangle
   assign fields_clear = (rsp.status == ST_ALLOC) ||
                         ((rsp.out_x == '0) && (rsp.out_y == '0) &&
                          (rsp.out_w == '0) && (rsp.out_h == '0));

   `CHK_ALWAYS(a_status_range, (!rsp_valid || (rsp.status <= ST_IGNORED)), "bad status code")

   `CHK_ALWAYS(a_zero_fields, (!rsp_valid || fields_clear), "nonzero fields on non-allocate result")

   // one item in flight: an accepted item closes the input until its result is out
   `CHK_NEXT(a_busy_after_accept, (req_valid && !req_stall), req_stall, "input open right after accept")

   `CHK_NEXT(a_rsp_hold, (rsp_valid && rsp_stall), (rsp_valid && $stable(rsp)), "stalled result changed")

endmodule

bind guillotine_rect_allocator gra_check u_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

// ----- sim/guillotine_rect_allocator_test.sv -----
// ----------------------------------------------------------------------------
// guillotine_rect_allocator_test
// drives allocate and free items through the allocator, predicts each result
// from a local copy of the free rectangle list and checks every field in order
// ----------------------------------------------------------------------------
module guillotine_rect_allocator_test;
   import gra_pkg::*;

   localparam int ATLAS_W     = 2048;
   localparam int ATLAS_H     = 2048;
   localparam int MAX_FREE    = 64;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_LIMIT = 4000;
   localparam int TAIL_CYCLES = 80;
   localparam int MAX_REPORTS = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   guillotine_rect_allocator #(
      .ATLAS_W  (ATLAS_W),
      .ATLAS_H  (ATLAS_H),
      .MAX_FREE (MAX_FREE)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   always #10 clock = ~clock;

   rect_type free_list [MAX_FREE];
   int       live_count;
   rsp_type  expected_rsp [$];
   rect_type held_rects [$];
   int       error_count = 0;
   bit       quiet       = 1'b0;
   int       stall_left  = 0;
   int       cycle_count = 0;
   rsp_type  want;

   function automatic void reset_atlas();
      for (int i = 0; i < MAX_FREE; i++) begin
         free_list[i] = '0;
      end
      free_list[0].w = SIZE_W'(ATLAS_W);
      free_list[0].h = SIZE_W'(ATLAS_H);
      live_count = 1;
   endfunction

   // first fit, guillotine split, swap-remove of the chosen entry on an exact fit
   function automatic rsp_type predict_placement(req_type item);
      rsp_type  res;
      rect_type fr;
      rect_type rs;
      rect_type bs;
      int       n;
      int       hit;
      logic     right;
      logic     bottom;
      res = '0;
      n   = live_count;
      if (item.cmd == CMD_FREE) begin
         if (item.rect_w == 0 || item.rect_h == 0) begin
            res.status = ST_IGNORED;
         end else if (n >= MAX_FREE) begin
            res.status = ST_FULL;
         end else begin
            free_list[n].x = item.rect_x;
            free_list[n].y = item.rect_y;
            free_list[n].w = item.rect_w;
            free_list[n].h = item.rect_h;
            live_count = n + 1;
            res.status = ST_FREED;
         end
         return res;
      end
      hit = -1;
      for (int i = 0; i < n; i++) begin
         if (hit < 0 && item.rect_w <= free_list[i].w && item.rect_h <= free_list[i].h) begin
            hit = i;
         end
      end
      if (hit < 0) begin
         res.status = ST_NOFIT;
         return res;
      end
      fr     = free_list[hit];
      right  = fr.w > item.rect_w;
      bottom = fr.h > item.rect_h;
      if (right && bottom && n + 1 > MAX_FREE) begin
         res.status = ST_FULL;
         return res;
      end
      // strip edges wrap to the coordinate width
      rs.x = fr.x + item.rect_w[POS_W-1:0];
      rs.y = fr.y;
      rs.w = fr.w - item.rect_w;
      rs.h = fr.h;
      bs.x = fr.x;
      bs.y = fr.y + item.rect_h[POS_W-1:0];
      bs.w = item.rect_w;
      bs.h = fr.h - item.rect_h;
      if (right && bottom) begin
         free_list[n]   = rs;
         free_list[hit] = bs;
         live_count     = n + 1;
      end else if (right) begin
         free_list[hit] = rs;
      end else if (bottom) begin
         free_list[hit] = bs;
      end else begin
         free_list[hit] = free_list[n-1];
         live_count     = n - 1;
      end
      res.status = ST_ALLOC;
      res.out_x  = fr.x;
      res.out_y  = fr.y;
      res.out_w  = item.rect_w;
      res.out_h  = item.rect_h;
      return res;
   endfunction

   function automatic req_type make_req(logic cmd, int x, int y, int w, int h);
      req_type item;
      item.cmd    = cmd;
      item.rect_x = POS_W'(x);
      item.rect_y = POS_W'(y);
      item.rect_w = SIZE_W'(w);
      item.rect_h = SIZE_W'(h);
      return item;
   endfunction

   function automatic int small_size();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 0;
      end else if (r < 8) begin
         return $urandom_range(1, 64);
      end
      return $urandom_range(65, 1024);
   endfunction

   task automatic send_item(input req_type item);
      rsp_type  predicted;
      rect_type got_rect;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_placement(item);
      expected_rsp = {expected_rsp, predicted};
      if (predicted.status == ST_ALLOC) begin
         got_rect.x = predicted.out_x;
         got_rect.y = predicted.out_y;
         got_rect.w = predicted.out_w;
         got_rect.h = predicted.out_h;
         held_rects = {held_rects, got_rect};
      end
   endtask

   // position fields are don't-care on allocate, so they carry noise
   task automatic send_alloc(input int w, input int h);
      send_item(make_req(CMD_ALLOC, $urandom_range(0, 4095), $urandom_range(0, 4095), w, h));
   endtask

   task automatic send_free(input int x, input int y, input int w, input int h);
      send_item(make_req(CMD_FREE, x, y, w, h));
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (expected_rsp.size() != 0 && waited < DRAIN_LIMIT);
   endtask

   task automatic test_corner_cases();
      send_alloc(4096, 4096);          // larger than the atlas
      send_alloc(0, 0);                // zero size still splits
      send_alloc(2048, 2048);
      send_alloc(0, 2048);             // exact fit empties the list
      send_alloc(1, 1);                // empty list
      send_alloc(0, 0);
      send_free(100, 200, 0, 7);
      send_free(300, 400, 7, 0);
      send_free(4095, 4095, 4096, 4096);
      send_alloc(1, 1);                // strip edges wrap
      send_free(0, 0, 2048, 2048);
      send_alloc(4096, 1);
      send_alloc(1, 4096);
      send_alloc(2048, 100);
      send_alloc(100, 2048);
      send_alloc(64, 64);
      send_alloc(4095, 4095);
      send_free(0, 4095, 4096, 1);
      send_free(4095, 0, 1, 4096);
      send_alloc(4096, 1);
      wait_drained();
   endtask

   task automatic test_list_full();
      rect_type head;
      while (live_count < MAX_FREE) begin
         send_free($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(1, 64), $urandom_range(1, 64));
      end
      send_free(10, 10, 16, 16);
      send_free(10, 10, 0, 16);        // zero size wins over full
      send_alloc(0, 0);
      head = free_list[0];
      send_alloc(head.w, head.h);
      send_free(20, 20, 32, 32);
      head = free_list[0];
      send_alloc(head.w, (head.h > 1) ? head.h - 1 : head.h);
      head = free_list[0];
      send_alloc((head.w > 1) ? head.w - 1 : head.w, head.h);
      wait_drained();
      // an exact fit of the head entry always shrinks the list by one
      while (live_count > 4) begin
         head = free_list[0];
         send_alloc(head.w, head.h);
      end
      send_free(0, 0, 2048, 2048);
   endtask

   task automatic test_mixed_traffic(input int n_items);
      int       kind;
      int       k;
      int       w;
      int       h;
      rect_type pick;
      repeat (n_items) begin
         kind = $urandom_range(0, 99);
         if (live_count >= MAX_FREE - 2 && kind < 40) begin
            send_alloc(free_list[0].w, free_list[0].h);
         end else if (kind < 35) begin
            send_alloc(small_size(), small_size());
         end else if (kind < 50 && live_count > 0) begin
            k = $urandom_range(0, live_count - 1);
            send_alloc(free_list[k].w, free_list[k].h);
         end else if (kind < 82 && held_rects.size() > 0) begin
            k    = $urandom_range(0, held_rects.size() - 1);
            pick = held_rects[k];
            held_rects.delete(k);
            send_free(pick.x, pick.y, pick.w, pick.h);
         end else if (kind < 92) begin
            w = $urandom_range(0, 4096);
            h = $urandom_range(0, 4096);
            if ($urandom_range(0, 7) == 0) w = 0;
            if ($urandom_range(0, 7) == 0) h = 0;
            send_free($urandom_range(0, 4095), $urandom_range(0, 4095), w, h);
         end else begin
            send_alloc($urandom_range(0, 4096), $urandom_range(0, 4096));
         end
      end
   endtask

   // result check and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("unexpected item: st=%0d x=%0d y=%0d w=%0d h=%0d",
                           rsp.status, rsp.out_x, rsp.out_y, rsp.out_w, rsp.out_h);
               end
            end else begin
               want = expected_rsp.pop_front();
               if (rsp.status !== want.status || rsp.out_x !== want.out_x ||
                   rsp.out_y !== want.out_y || rsp.out_w !== want.out_w ||
                   rsp.out_h !== want.out_h) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("mismatch: want st=%0d x=%0d y=%0d w=%0d h=%0d,",
                              want.status, want.out_x, want.out_y, want.out_w,
                              want.out_h,
                              " got st=%0d x=%0d y=%0d w=%0d h=%0d",
                              rsp.status, rsp.out_x, rsp.out_y, rsp.out_w, rsp.out_h);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13);
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset_atlas();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_list_full();
      test_mixed_traffic(1100);
      quiet = 1'b1;
      test_mixed_traffic(200);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         error_count++;
         $display("missing items: %0d", expected_rsp.size());
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gra_pkg.sv
rtl/gra_ram.sv
rtl/gra_ctrl.sv
rtl/gra_dp.sv
rtl/guillotine_rect_allocator.sv
rtl/gra_check.sv
sim/guillotine_rect_allocator_test.sv
